// ===== hdl/dpq_pkg.sv =====
// dpq_pkg: shared types and constants for the delayed pulse queue
// item structs, operation codes, controller states and command group
// no dependencies
package dpq_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int DELAY_BITS_DEF = 24;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_POLL = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [23:0] delay;
  } in_item_t;

  typedef struct packed {
    logic       pulse;
    logic       add_dropped;
    logic [4:0] pending;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } dpq_cmd_t;

endpackage

// ===== hdl/delayed_pulse_queue_top.sv =====
// delayed_pulse_queue_top: top level of the delayed pulse queue
// joins the controller and the datapath
// depends on dpq_pkg, dpq_ctrl, dpq_datapath
//
// usage
//   input: drive in_data and raise start; the item is taken at a rising edge
//   with start high and busy low. op tick counts every pending slot down,
//   op add appends a slot with the given delay, op poll removes the oldest
//   expired slot and reports a pulse
//   output: out_data is valid for exactly one cycle while out_valid is high;
//   every item gives one result, carrying pulse, add_dropped and the count
//   of pending slots after the item
//   timing: an item taken at edge n is executed in the following cycle and
//   its result is strobed in the cycle after that; busy is high for that
//   one execute cycle, so a new item is taken only after the load and
//   execute steps of the controller
//   the result register lets a new item be taken while a result is shown
//   reset: synchronous active low rst_n empties the list, no clearing pass
//   the receiver cannot stall; results are never held
module delayed_pulse_queue_top
  import dpq_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int DELAY_BITS = DELAY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  dpq_cmd_t cmd;

  dpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  dpq_datapath #(
    .SLOTS      (SLOTS),
    .DELAY_BITS (DELAY_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ===== hdl/dpq_ctrl.sv =====
// dpq_ctrl: sequencing state machine for the delayed pulse queue
// issues load and execute commands to the datapath, drives busy and strobe
// depends on dpq_pkg
module dpq_ctrl
  import dpq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_valid,
  output dpq_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.exec;
    end
  end

  always_comb begin
    state_nxt = state_r;
    busy      = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy      = 1'b1;
        cmd.exec  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hdl/dpq_datapath.sv =====
// dpq_datapath: slot countdown registers, expiry flags, count and result register
// updates all slots in parallel on an execute command
// depends on dpq_pkg
module dpq_datapath
  import dpq_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int DELAY_BITS = DELAY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dpq_cmd_t  cmd,
  input  in_item_t  in_data,
  output out_item_t out_data
);

  localparam int CNT_W = $clog2(SLOTS + 1);

  logic [1:0]            op_r;
  logic [23:0]           delay_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [DELAY_BITS-1:0] slot_r   [SLOTS];
  logic [DELAY_BITS-1:0] slot_nxt [SLOTS];
  logic [SLOTS-1:0]      zero_r, zero_nxt;
  out_item_t             out_r, out_nxt;

  logic [DELAY_BITS-1:0] delay_ext;
  logic [SLOTS-1:0]      valid, hit, below, shift_mask;
  logic                  full, found;

  always_comb begin
    delay_ext = DELAY_BITS'(delay_r);
    full      = (count_r == CNT_W'(SLOTS));
    for (int j = 0; j < SLOTS; j++) begin
      valid[j] = (CNT_W'(j) < count_r);
    end
    hit        = valid & zero_r;
    found      = |hit;
    // bits below the oldest expired slot
    below      = (hit - SLOTS'(1)) & ~hit;
    shift_mask = ~below;

    slot_nxt  = slot_r;
    zero_nxt  = zero_r;
    count_nxt = count_r;
    out_nxt   = '0;

    case (op_r)
      OP_TICK: begin
        for (int j = 0; j < SLOTS; j++) begin
          if (slot_r[j] != '0) begin
            slot_nxt[j] = slot_r[j] - DELAY_BITS'(1);
          end
          zero_nxt[j] = (slot_r[j] == '0) || (slot_r[j] == DELAY_BITS'(1));
        end
      end
      OP_ADD: begin
        if (full) begin
          out_nxt.add_dropped = 1'b1;
        end else begin
          for (int j = 0; j < SLOTS; j++) begin
            if (count_r == CNT_W'(j)) begin
              slot_nxt[j] = delay_ext;
              zero_nxt[j] = (delay_ext == '0);
            end
          end
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_POLL: begin
        if (found) begin
          for (int j = 0; j < SLOTS - 1; j++) begin
            if (shift_mask[j]) begin
              slot_nxt[j] = slot_r[j+1];
              zero_nxt[j] = zero_r[j+1];
            end
          end
          count_nxt     = count_r - CNT_W'(1);
          out_nxt.pulse = 1'b1;
        end
      end
      default: begin
      end
    endcase
    out_nxt.pending = 5'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_data.op;
      delay_r <= in_data.delay;
    end
    if (cmd.exec) begin
      slot_r <= slot_nxt;
      zero_r <= zero_nxt;
      out_r  <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

// ===== sim/delayed_pulse_queue_top_tb.sv =====
// delayed_pulse_queue_top_tb: self-checking testbench for delayed_pulse_queue_top
// directed and phased random tick/add/poll/unused items, checked against a local timer-list model
// depends on dpq_pkg and delayed_pulse_queue_top
module delayed_pulse_queue_top_tb
  import dpq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         RANDOM_ITEMS = 2000;
  localparam int         IDLE_LIMIT   = 200;
  localparam int         DRAIN_CYCLES = 6;
  localparam int         MAX_PRINTS   = 50;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_t;

  typedef struct {
    in_item_t    item;
    int unsigned gap;
  } stim_rec_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_data = '0;
  logic      out_valid;
  out_item_t out_data;

  stim_rec_t   stim_q[$];
  out_item_t   expected_status_q[$];
  stim_rec_t   next_rec;
  int unsigned gap_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned err_count = 0;

  logic [DELAY_BITS_DEF-1:0] slot_ticks[SLOTS_DEF];
  int                        slot_count = 0;

  delayed_pulse_queue_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_PRINTS) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
  endtask

  function automatic out_item_t predict_queue_status(input in_item_t it);
    out_item_t r;
    int        hit;
    r = '0;
    hit = -1;
    case (it.op)
      OP_TICK: begin
        for (int i = 0; i < slot_count; i++) begin
          if (slot_ticks[i] != '0) slot_ticks[i] = slot_ticks[i] - 1'b1;
        end
      end
      OP_ADD: begin
        if (slot_count >= SLOTS_DEF) begin
          r.add_dropped = 1'b1;
        end else begin
          slot_ticks[slot_count] = it.delay;
          slot_count++;
        end
      end
      OP_POLL: begin
        for (int i = 0; i < slot_count; i++) begin
          if (hit < 0 && slot_ticks[i] == '0) hit = i;
        end
        if (hit >= 0) begin
          for (int j = hit; j + 1 < slot_count; j++) slot_ticks[j] = slot_ticks[j+1];
          slot_count--;
          r.pulse = 1'b1;
        end
      end
      default: ;
    endcase
    r.pending = 5'(slot_count);
    return r;
  endfunction

  task automatic queue_item(input logic [1:0] op, input logic [23:0] dly,
                            input int unsigned gap);
    stim_rec_t r;
    r.item.op = op;
    r.item.delay = dly;
    r.gap = gap;
    stim_q.push_back(r);
  endtask

  function automatic logic [1:0] pick_op(input int unsigned roll, input int unsigned add_pct,
                                         input int unsigned tick_pct, input int unsigned poll_pct);
    if (roll < add_pct) return OP_ADD;
    if (roll < add_pct + tick_pct) return OP_TICK;
    if (roll < add_pct + tick_pct + poll_pct) return OP_POLL;
    return OP_UNUSED;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
      slot_count = 0;
    end else begin
      if (start && !busy) begin
        expected_status_q.push_back(predict_queue_status(in_data));
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (stim_q.size() > 0) begin
          next_rec = stim_q.pop_front();
          in_data <= next_rec.item;
          gap_left <= next_rec.gap;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_status_q.size() == 0) begin
        report_mismatch("result strobed with no item outstanding");
      end else begin
        automatic out_item_t want = expected_status_q.pop_front();
        if (out_data.pulse !== want.pulse)
          report_mismatch($sformatf("pulse got %b want %b", out_data.pulse, want.pulse));
        if (out_data.add_dropped !== want.add_dropped)
          report_mismatch($sformatf("add_dropped got %b want %b",
                                    out_data.add_dropped, want.add_dropped));
        if (out_data.pending !== want.pending)
          report_mismatch($sformatf("pending got %0d want %0d",
                                    out_data.pending, want.pending));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    phase_t      phase;
    int unsigned phase_left;
    int unsigned roll;
    bit          calm;
    logic [1:0]  op;
    logic [23:0] dly;

    phase = PH_MIX;
    phase_left = 0;
    calm = 1'b0;

    // empty list cases, unused op, zero delay, oldest expired pick, full list drop
    queue_item(OP_POLL, 24'($urandom()), 0);
    queue_item(OP_TICK, 24'($urandom()), 1);
    queue_item(OP_UNUSED, 24'($urandom()), 0);
    queue_item(OP_ADD, 24'd0, 0);
    queue_item(OP_POLL, 24'd0, 2);
    queue_item(OP_ADD, 24'd3, 0);
    queue_item(OP_ADD, 24'd1, 0);
    queue_item(OP_TICK, 24'd0, 0);
    queue_item(OP_POLL, 24'd0, 0);
    queue_item(OP_POLL, 24'd0, 3);
    for (int i = 0; i < SLOTS_DEF - 1; i++) begin
      queue_item(OP_ADD, 24'($urandom_range(0, 6)), $urandom_range(0, 2));
    end
    queue_item(OP_ADD, 24'hFFFFFF, 0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase = phase_t'($urandom_range(0, 2));
        phase_left = $urandom_range(20, 60);
        calm = ($urandom_range(0, 2) == 0);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      case (phase)
        PH_FILL:  op = pick_op(roll, 60, 20, 15);
        PH_DRAIN: op = pick_op(roll, 10, 40, 45);
        default:  op = pick_op(roll, 35, 30, 30);
      endcase
      if (op == OP_ADD) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) dly = 24'($urandom_range(0, 4));
        else if (roll < 95) dly = 24'($urandom_range(0, 20));
        else dly = 24'($urandom_range(0, 200));
      end else begin
        dly = 24'($urandom());
      end
      queue_item(op, dly, calm ? 0 : $urandom_range(0, 16));
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (stim_q.size() != 0 || start || expected_status_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_status_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_status_q.size()));
    end

    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/dpq_pkg.sv
hdl/dpq_ctrl.sv
hdl/dpq_datapath.sv
hdl/delayed_pulse_queue_top.sv
sim/delayed_pulse_queue_top_tb.sv
